[rtl/core/a2ab_pkg.sv]
// ----------------------------------------------------------------------------
// a2ab_pkg
// Shared types and constants for the AVCC to Annex B byte stream converter.
// ----------------------------------------------------------------------------
package a2ab_pkg;

	// result item kinds
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_SHORT    = 2'd1,
		ERR_ZERO_LEN = 2'd2,
		ERR_OVERRUN  = 2'd3
	} err_t;

	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned PREFIX_MAX  = 4;

	localparam logic [2:0]  PREFIX_RESET  = 3'd4;
	localparam logic [31:0] NON_SYNC_BIT  = 32'h0001_0000;
	localparam logic [4:0]  NAL_TYPE_IDR  = 5'd5;

	// annex b start code, sent first to last
	localparam logic [7:0] START_CODE [MAX_RESULTS] = '{8'h00, 8'h00, 8'h00, 8'h01};

endpackage

[rtl/core/avcc_to_annexb_converter.sv]
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Turns length-prefixed NAL units into an Annex B stream with access unit
// summaries and sticky error reporting.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register, before
// its first result is valid; it waits in the input register while results drain.
// Throughput: one item per cycle while each item gives one result and out_stall is low;
// an item with k results (k = 4 on a start code) holds the result register till drained.
// Reset: control state, running time and error latch clear; prefix size is 4.
module avcc_to_annexb_converter
	import a2ab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  length_prefix_bytes,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        sample_first,
	input  logic        sample_last,
	input  logic [31:0] sample_flags,
	input  logic [31:0] sample_duration,
	input  logic        time_load,
	input  logic [63:0] start_time,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  item_kind,
	output logic [7:0]  out_byte,
	output logic        is_key,
	output logic [63:0] decode_time,
	output logic [31:0] unit_duration,
	output logic [1:0]  error_code,
	output logic        run_last
);

	// configuration register
	logic [2:0] prefix_cfg_q;

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic [31:0] flags_s1;
	logic [31:0] dur_s1;
	logic        load_s1;
	logic [63:0] start_s1;

	// parser state
	logic [63:0] rt_q;
	logic [31:0] acc_q;
	logic [2:0]  pc_q;
	logic [31:0] rem_q;
	logic        inb_q;
	logic        fbb_q;
	logic [2:0]  sbc_q;
	logic        idr_q;
	logic [31:0] flags_q;
	logic [31:0] dur_q;
	logic        failed_q;
	err_t        code_q;

	// result buffer
	kind_t       ent_kind_q [MAX_RESULTS];
	logic [7:0]  ent_byte_q [MAX_RESULTS];
	err_t        ent_err_q  [MAX_RESULTS];
	logic        key_q;
	logic [63:0] dts_q;
	logic [31:0] udur_q;
	logic [2:0]  cnt_q;
	logic [1:0]  idx_q;

	// handshake
	logic in_accept, out_accept, drain_done, buf_free, fire;

	// next values
	kind_t       nk [MAX_RESULTS];
	logic [7:0]  nb [MAX_RESULTS];
	err_t        ne [MAX_RESULTS];
	logic [2:0]  n;
	logic        sum_key;
	logic [63:0] sum_dts;
	logic [31:0] sum_dur;
	logic [2:0]  size;
	logic [63:0] rt_e, rt_d;
	logic [31:0] acc_e, acc_d, rem_e, rem_d, flags_e, dur_e, acc_n;
	logic [2:0]  pc_e, pc_d, sbc_e, sbc_d;
	logic        inb_e, inb_d, fbb_e, fbb_d, idr_e, idr_d;
	logic        fail_d;
	err_t        code_d, err_v;
	logic        err_raise;

	assign cfg_ready = 1'b1;

	// handshake control
	assign out_valid  = (cnt_q != 3'd0);
	assign out_accept = out_valid && !out_stall;
	assign drain_done = out_accept && ({1'b0, idx_q} == cnt_q - 3'd1);
	assign buf_free   = (cnt_q == 3'd0) || drain_done;
	assign fire       = valid_s1 && buf_free;
	assign in_stall   = valid_s1 && !buf_free;
	assign in_accept  = in_valid && !in_stall;

	// effective prefix size
	always_comb begin
		if (prefix_cfg_q == 3'd0)
			size = 3'd1;
		else if (prefix_cfg_q > 3'(PREFIX_MAX))
			size = 3'(PREFIX_MAX);
		else
			size = prefix_cfg_q;
	end

	// one item's results and next state
	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			nk[i] = KIND_BYTE;
			nb[i] = 8'h00;
			ne[i] = ERR_NONE;
		end
		n         = 3'd0;
		err_raise = 1'b0;
		err_v     = ERR_NONE;

		// sample start latches and clears the parser
		flags_e = first_s1 ? flags_s1 : flags_q;
		dur_e   = first_s1 ? dur_s1 : dur_q;
		rt_e    = (first_s1 && load_s1) ? start_s1 : rt_q;
		acc_e   = first_s1 ? 32'd0 : acc_q;
		pc_e    = first_s1 ? 3'd0 : pc_q;
		rem_e   = first_s1 ? 32'd0 : rem_q;
		inb_e   = first_s1 ? 1'b0 : inb_q;
		fbb_e   = first_s1 ? 1'b0 : fbb_q;
		sbc_e   = first_s1 ? 3'd0 : sbc_q;
		idr_e   = first_s1 ? 1'b0 : idr_q;

		acc_d  = acc_e;
		pc_d   = pc_e;
		rem_d  = rem_e;
		inb_d  = inb_e;
		fbb_d  = fbb_e;
		idr_d  = idr_e;
		rt_d   = rt_e;
		sbc_d  = (sbc_e < 3'(PREFIX_MAX)) ? sbc_e + 3'd1 : sbc_e;
		fail_d = failed_q;
		code_d = code_q;
		acc_n  = {acc_e[23:0], byte_s1};

		sum_key = idr_e || (((flags_e & NON_SYNC_BIT) == 32'd0) && (flags_e != 32'd0));
		sum_dts = rt_e;
		sum_dur = dur_e;

		if (failed_q) begin
			nk[0] = KIND_ERROR;
			ne[0] = code_q;
			n     = 3'd1;
		end else begin
			// prefix gathering or body pass-through
			if (!inb_e) begin
				acc_d = acc_n;
				pc_d  = (pc_e < 3'd7) ? pc_e + 3'd1 : pc_e;
				if (pc_d >= size) begin
					if (acc_n == 32'd0) begin
						err_raise = 1'b1;
						err_v     = ERR_ZERO_LEN;
					end else if (last_s1) begin
						err_raise = 1'b1;
						err_v     = ERR_OVERRUN;
					end else begin
						inb_d = 1'b1;
						fbb_d = 1'b1;
						rem_d = acc_n;
						acc_d = 32'd0;
						pc_d  = 3'd0;
						for (int i = 0; i < MAX_RESULTS; i++)
							nb[i] = START_CODE[i];
						n = 3'd4;
					end
				end
			end else begin
				if (fbb_e && (byte_s1[4:0] == NAL_TYPE_IDR))
					idr_d = 1'b1;
				fbb_d = 1'b0;
				nb[0] = byte_s1;
				n     = 3'd1;
				rem_d = rem_e - 32'd1;
				if (rem_d == 32'd0)
					inb_d = 1'b0;
			end

			// end of sample checks and summary
			if (last_s1 && !err_raise) begin
				if (sbc_d < size) begin
					err_raise = 1'b1;
					err_v     = ERR_SHORT;
				end else if (inb_d) begin
					err_raise = 1'b1;
					err_v     = ERR_OVERRUN;
				end else begin
					nk[n[1:0]] = KIND_SUMMARY;
					n          = n + 3'd1;
					sum_key    = idr_d || (((flags_e & NON_SYNC_BIT) == 32'd0) &&
						(flags_e != 32'd0));
					rt_d       = rt_e + {32'd0, dur_e};
					acc_d = 32'd0; pc_d = 3'd0; rem_d = 32'd0; inb_d = 1'b0;
					fbb_d = 1'b0; sbc_d = 3'd0; idr_d = 1'b0;
				end
			end

			// error goes last and latches
			if (err_raise) begin
				nk[n[1:0]] = KIND_ERROR;
				ne[n[1:0]] = err_v;
				n          = n + 3'd1;
				fail_d     = 1'b1;
				code_d     = err_v;
				acc_d = 32'd0; pc_d = 3'd0; rem_d = 32'd0; inb_d = 1'b0;
				fbb_d = 1'b0; sbc_d = 3'd0; idr_d = 1'b0;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prefix_cfg_q <= PREFIX_RESET;
		else if (cfg_valid && cfg_ready)
			prefix_cfg_q <= length_prefix_bytes;
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_accept)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= data_byte;
			first_s1 <= sample_first;
			last_s1  <= sample_last;
			flags_s1 <= sample_flags;
			dur_s1   <= sample_duration;
			load_s1  <= time_load;
			start_s1 <= start_time;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q     <= 64'd0;
			acc_q    <= 32'd0;
			pc_q     <= 3'd0;
			rem_q    <= 32'd0;
			inb_q    <= 1'b0;
			fbb_q    <= 1'b0;
			sbc_q    <= 3'd0;
			idr_q    <= 1'b0;
			flags_q  <= 32'd0;
			dur_q    <= 32'd0;
			failed_q <= 1'b0;
			code_q   <= ERR_NONE;
		end else if (fire && !failed_q) begin
			rt_q     <= rt_d;
			acc_q    <= acc_d;
			pc_q     <= pc_d;
			rem_q    <= rem_d;
			inb_q    <= inb_d;
			fbb_q    <= fbb_d;
			sbc_q    <= sbc_d;
			idr_q    <= idr_d;
			flags_q  <= flags_e;
			dur_q    <= dur_e;
			failed_q <= fail_d;
			code_q   <= code_d;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (fire) begin
			cnt_q <= n;
			idx_q <= 2'd0;
		end else if (drain_done) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (out_accept) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				ent_kind_q[i] <= nk[i];
				ent_byte_q[i] <= nb[i];
				ent_err_q[i]  <= ne[i];
			end
			key_q  <= sum_key;
			dts_q  <= sum_dts;
			udur_q <= sum_dur;
		end
	end

	// output fields, zero where the kind does not use them
	always_comb begin
		item_kind     = ent_kind_q[idx_q];
		out_byte      = (ent_kind_q[idx_q] == KIND_BYTE) ? ent_byte_q[idx_q] : 8'h00;
		is_key        = (ent_kind_q[idx_q] == KIND_SUMMARY) ? key_q : 1'b0;
		decode_time   = (ent_kind_q[idx_q] == KIND_SUMMARY) ? dts_q : 64'd0;
		unit_duration = (ent_kind_q[idx_q] == KIND_SUMMARY) ? udur_q : 32'd0;
		error_code    = (ent_kind_q[idx_q] == KIND_ERROR) ? ent_err_q[idx_q] : ERR_NONE;
		run_last      = ({1'b0, idx_q} == cnt_q - 3'd1);
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(MAX_RESULTS))
		else $error("result count out of range");

	a_failed_single: assert property (@(posedge clk) disable iff (!arst_n)
		fire && failed_q |=> cnt_q == 3'd1 && ent_kind_q[0] == KIND_ERROR)
		else $error("failed state gave other than one error item");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		inb_q |-> rem_q != 32'd0)
		else $error("in body with nothing remaining");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (item_kind == KIND_SUMMARY || item_kind == KIND_ERROR) |-> run_last)
		else $error("summary or error not last in run");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AVCC to Annex B converter. A directed table of
// samples comes first, then random samples under each prefix size setting,
// then one sticky error at the very end. Every accepted byte is run through
// a predictor, and every result transfer is compared field by field with
// the oldest expected item.
// ----------------------------------------------------------------------------
module tb;
	import a2ab_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1000;
	localparam int LONG_HOLD = 60;
	localparam int PHASE_ITEMS = 36;
	localparam logic [2:0] PHASE_PREFIX [10] = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd7,
		3'd4, 3'd5, 3'd6, 3'd2, 3'd1};

	// one input byte with its sample side fields
	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] flags;
		logic [31:0] dur;
		logic        tload;
		logic [63:0] stime;
	} payload_t;

	// one output stream item
	typedef struct {
		kind_t       kind;
		logic [7:0]  obyte;
		logic        key;
		logic [63:0] dts;
		logic [31:0] dur;
		err_t        err;
		logic        last;
	} stream_item_t;

	// directed row: stimulus, plus a typed summary where it is obvious
	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [31:0] flags;
		logic [31:0] dur;
		logic        tload;
		logic [63:0] stime;
		logic        typed;
		logic        key;
		logic [63:0] dts;
		logic [31:0] exp_dur;
	} dir_row_t;

	dir_row_t dir_rows [24] = '{
		// idr sample, time reloaded to zero
		'{8'h00, 1'b1, 1'b0, 32'h0, 32'd100, 1'b1, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h02, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h65, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'hff, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0, 64'h0, 1'b1, 1'b1, 64'd0, 32'd100},
		// sample with no start marker reuses the latched flags and duration
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h01, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h41, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0, 64'h0, 1'b1, 1'b0, 64'd100, 32'd100},
		// abandoned sample, cut off by the next sample start
		'{8'h00, 1'b1, 1'b0, 32'h1234_5678, 32'd7, 1'b1, 64'haaaa_aaaa_aaaa_aaaa,
			1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		// non-sync flags, max time and duration, trailing partial prefix dropped
		'{8'h00, 1'b1, 1'b0, 32'h0201_0000, 32'hffff_ffff, 1'b1, 64'hffff_ffff_ffff_ffff,
			1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h01, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h21, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'haa, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0, 64'h0, 1'b1, 1'b0,
			64'hffff_ffff_ffff_ffff, 32'hffff_ffff},
		// sync flags give a key frame, running time has wrapped
		'{8'h00, 1'b1, 1'b0, 32'h0000_0040, 32'd5, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h00, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h01, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 32'h0},
		'{8'h09, 1'b0, 1'b1, 32'h0, 32'h0, 1'b0, 64'h0, 1'b1, 1'b1, 64'h0000_0000_ffff_fffe,
			32'd5}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  length_prefix_bytes = PREFIX_RESET;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        sample_first = 1'b0;
	logic        sample_last = 1'b0;
	logic [31:0] sample_flags = 32'h0;
	logic [31:0] sample_duration = 32'h0;
	logic        time_load = 1'b0;
	logic [63:0] start_time = 64'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  item_kind;
	logic [7:0]  out_byte;
	logic        is_key;
	logic [63:0] decode_time;
	logic [31:0] unit_duration;
	logic [1:0]  error_code;
	logic        run_last;

	// predictor state
	logic [2:0]  prefix_setting = PREFIX_RESET;
	logic [63:0] run_time = 64'h0;
	logic [31:0] len_acc = 32'h0;
	logic [2:0]  pfx_count = 3'd0;
	logic [31:0] body_left = 32'h0;
	logic        in_nal = 1'b0;
	logic        at_nal_head = 1'b0;
	logic [2:0]  bytes_seen = 3'd0;
	logic        idr_found = 1'b0;
	logic [31:0] flags_hold = 32'h0;
	logic [31:0] dur_hold = 32'h0;
	logic        stuck = 1'b0;
	err_t        stuck_code = ERR_NONE;

	stream_item_t expected_stream [$];
	stream_item_t step_results [$];
	payload_t     sample_q [$];

	bit calm = 1'b0;
	bit long_hold_done = 1'b0;
	int results_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	avcc_to_annexb_converter i_dut (.*);

	always #1 clk = ~clk;

	// mismatch reporting
	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		$display("%0t ns: %s got %0h want %0h", $time, what, got, want);
	endtask

	function automatic int eff_size(input logic [2:0] setting);
		if (setting == 3'd0)
			return 1;
		if (setting > 3'(PREFIX_MAX))
			return PREFIX_MAX;
		return int'(setting);
	endfunction

	// random side fields, chosen byte and sample marks
	function automatic payload_t make_item(input logic [7:0] d, input logic f, input logic l);
		payload_t it;
		it.data = d;
		it.first = f;
		it.last = l;
		it.flags = $urandom;
		it.dur = $urandom;
		it.tload = 1'($urandom);
		it.stime = {$urandom, $urandom};
		return it;
	endfunction

	task automatic clear_parser();
		len_acc = 32'h0;
		pfx_count = 3'd0;
		body_left = 32'h0;
		in_nal = 1'b0;
		at_nal_head = 1'b0;
		bytes_seen = 3'd0;
		idr_found = 1'b0;
	endtask

	task automatic set_failed(input err_t code);
		stuck = 1'b1;
		stuck_code = code;
		clear_parser();
		step_results.insert(step_results.size(),
			'{KIND_ERROR, 8'h00, 1'b0, 64'h0, 32'h0, code, 1'b0});
	endtask

	// predictor: results caused by one accepted byte
	task automatic convert_byte(input payload_t it);
		int sz;
		bit done;
		sz = eff_size(prefix_setting);
		done = 1'b0;
		if (stuck) begin
			step_results.insert(step_results.size(),
				'{KIND_ERROR, 8'h00, 1'b0, 64'h0, 32'h0, stuck_code, 1'b0});
		end else begin
			// sample start latches side fields and restarts parsing
			if (it.first) begin
				flags_hold = it.flags;
				dur_hold = it.dur;
				if (it.tload)
					run_time = it.stime;
				clear_parser();
			end
			if (bytes_seen < 3'd4)
				bytes_seen++;
			if (!in_nal) begin
				// gather length prefix, big endian
				len_acc = {len_acc[23:0], it.data};
				if (pfx_count < 3'd7)
					pfx_count++;
				if (pfx_count >= sz) begin
					if (len_acc == 32'h0) begin
						set_failed(ERR_ZERO_LEN);
						done = 1'b1;
					end else if (it.last) begin
						set_failed(ERR_OVERRUN);
						done = 1'b1;
					end else begin
						in_nal = 1'b1;
						at_nal_head = 1'b1;
						body_left = len_acc;
						len_acc = 32'h0;
						pfx_count = 3'd0;
						for (int i = 0; i < 4; i++)
							step_results.insert(step_results.size(), '{KIND_BYTE,
								START_CODE[i], 1'b0, 64'h0, 32'h0, ERR_NONE, 1'b0});
					end
				end
			end else begin
				// nal body byte passes through
				if (at_nal_head && it.data[4:0] == NAL_TYPE_IDR)
					idr_found = 1'b1;
				at_nal_head = 1'b0;
				step_results.insert(step_results.size(), '{KIND_BYTE, it.data, 1'b0,
					64'h0, 32'h0, ERR_NONE, 1'b0});
				body_left--;
				if (body_left == 32'h0)
					in_nal = 1'b0;
			end
			// sample end: summary or error
			if (!done && it.last) begin
				if (bytes_seen < sz) begin
					set_failed(ERR_SHORT);
				end else if (in_nal) begin
					set_failed(ERR_OVERRUN);
				end else begin
					step_results.insert(step_results.size(), '{KIND_SUMMARY, 8'h00,
						idr_found || ((flags_hold & NON_SYNC_BIT) == 32'h0 && flags_hold != 32'h0),
						run_time, dur_hold, ERR_NONE, 1'b0});
					run_time += 64'(dur_hold);
					clear_parser();
				end
			end
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i])
			expected_stream.insert(expected_stream.size(), step_results[i]);
		step_results.delete();
	endtask

	// one input transfer, with a random gap ahead of it
	task automatic send_item(input payload_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= it.data;
		sample_first <= it.first;
		sample_last <= it.last;
		sample_flags <= it.flags;
		sample_duration <= it.dur;
		time_load <= it.tload;
		start_time <= it.stime;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		convert_byte(it);
	endtask

	// register write once the block has drained
	task automatic write_prefix(input logic [2:0] value);
		in_valid <= 1'b0;
		while (expected_stream.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		length_prefix_bytes <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		prefix_setting = value;
	endtask

	// well-formed sample with random content, sometimes cut short
	task automatic build_sample(input int sz, input bit need_first, output bit cut);
		payload_t hdr;
		logic [2:0] hi;
		int nals;
		int len;
		int tail;
		sample_q.delete();
		nals = $urandom_range(1, 3);
		for (int k = 0; k < nals; k++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			for (int j = sz - 1; j >= 0; j--)
				sample_q.insert(sample_q.size(), make_item(8'(len >> (8 * j)), 1'b0, 1'b0));
			for (int j = 0; j < len; j++) begin
				hi = 3'($urandom);
				if (j == 0 && $urandom_range(0, 2) == 0)
					sample_q.insert(sample_q.size(), make_item({hi, NAL_TYPE_IDR}, 1'b0, 1'b0));
				else
					sample_q.insert(sample_q.size(), make_item(8'($urandom), 1'b0, 1'b0));
			end
		end
		// trailing bytes too few for a prefix
		tail = (sz > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, sz - 1) : 0;
		repeat (tail) sample_q.insert(sample_q.size(), make_item(8'($urandom), 1'b0, 1'b0));
		if (need_first || $urandom_range(0, 6) != 0) begin
			hdr = sample_q.pop_front();
			hdr.first = 1'b1;
			case ($urandom_range(0, 3))
				0: hdr.flags = 32'h0;
				1: hdr.flags = $urandom | NON_SYNC_BIT;
				2: hdr.flags = $urandom & ~NON_SYNC_BIT;
				default: hdr.flags = $urandom;
			endcase
			hdr.dur = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000);
			hdr.tload = ($urandom_range(0, 3) == 0);
			sample_q.push_front(hdr);
		end
		cut = ($urandom_range(0, 7) == 0);
		if (cut) begin
			repeat ($urandom_range(1, sample_q.size() - 1)) void'(sample_q.pop_back());
		end else begin
			hdr = sample_q.pop_back();
			hdr.last = 1'b1;
			sample_q.insert(sample_q.size(), hdr);
		end
	endtask

	// stimulus
	initial begin : stimulus
		payload_t it;
		dir_row_t r;
		int sent;
		bit need_first;
		bit cut;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at the reset prefix size
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			it = '{r.data, r.first, r.last, r.flags, r.dur, r.tload, r.stime};
			send_item(it);
			if (r.typed)
				expected_stream[expected_stream.size() - 1] = '{KIND_SUMMARY, 8'h00, r.key,
					r.dts, r.exp_dur, ERR_NONE, 1'b1};
		end

		// random samples under each prefix setting
		foreach (PHASE_PREFIX[p]) begin
			write_prefix(PHASE_PREFIX[p]);
			calm = (p % 4 == 2);
			sent = 0;
			need_first = 1'b1;
			while (sent < PHASE_ITEMS) begin
				build_sample(eff_size(PHASE_PREFIX[p]), need_first, cut);
				need_first = cut;
				foreach (sample_q[i])
					send_item(sample_q[i]);
				sent += sample_q.size();
			end
		end
		calm = 1'b0;

		// one sticky error at the end, then bytes that only repeat it
		write_prefix(3'd4);
		sample_q.delete();
		case ($urandom_range(0, 3))
			// sample shorter than a prefix
			0: sample_q = '{make_item(8'h00, 1'b1, 1'b0), make_item(8'h07, 1'b0, 1'b1)};
			// zero nal length
			1: sample_q = '{make_item(8'h00, 1'b1, 1'b0), make_item(8'h00, 1'b0, 1'b0),
				make_item(8'h00, 1'b0, 1'b0), make_item(8'h00, 1'b0, 1'b0)};
			// sample ends inside the body
			2: sample_q = '{make_item(8'h00, 1'b1, 1'b0), make_item(8'h00, 1'b0, 1'b0),
				make_item(8'h00, 1'b0, 1'b0), make_item(8'h03, 1'b0, 1'b0),
				make_item(8'h11, 1'b0, 1'b0), make_item(8'h22, 1'b0, 1'b1)};
			// prefix completes on the last byte
			default: sample_q = '{make_item(8'h00, 1'b1, 1'b0), make_item(8'h00, 1'b0, 1'b0),
				make_item(8'h00, 1'b0, 1'b0), make_item(8'h05, 1'b0, 1'b1)};
		endcase
		repeat (3) sample_q.insert(sample_q.size(),
			make_item(8'($urandom), 1'($urandom), 1'($urandom)));
		foreach (sample_q[i])
			send_item(sample_q[i]);
		in_valid <= 1'b0;

		// drain, then a short tail
		while (expected_stream.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls, one long hold-off, field checks
	initial begin : result_check
		int hold;
		stream_item_t want;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 3);
			if (!long_hold_done && results_seen >= 250) begin
				long_hold_done = 1'b1;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			results_seen++;
			if (expected_stream.size() == 0) begin
				report("result with nothing pending, item_kind", 64'(item_kind), 64'h0);
			end else begin
				want = expected_stream.pop_front();
				if (item_kind !== want.kind)
					report("item_kind", 64'(item_kind), 64'(want.kind));
				if (out_byte !== want.obyte)
					report("out_byte", 64'(out_byte), 64'(want.obyte));
				if (is_key !== want.key)
					report("is_key", 64'(is_key), 64'(want.key));
				if (decode_time !== want.dts)
					report("decode_time", decode_time, want.dts);
				if (unit_duration !== want.dur)
					report("unit_duration", 64'(unit_duration), 64'(want.dur));
				if (error_code !== want.err)
					report("error_code", 64'(error_code), 64'(want.err));
				if (run_last !== want.last)
					report("run_last", 64'(run_last), 64'(want.last));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

[files.f]
rtl/core/a2ab_pkg.sv
rtl/core/avcc_to_annexb_converter.sv
sim/tb.sv
